FILE: src/srs_pkg.sv
package srs_pkg;

  localparam int unsigned PairChars = 34;
  localparam logic [7:0] Undet = 8'hff;

  typedef struct packed {
    logic       hit;
    logic       closer;
    logic [4:0] pair;
  } pair_info_t;

  // a stack entry as held in one cell
  typedef struct packed {
    logic [4:0] pair;
    logic [7:0] script;
  } stk_entry_t;

  // bracket pair table lookup: openers at even places, closers at odd
  function automatic pair_info_t pair_lookup(input logic [20:0] cp);
    logic [20:0] tbl [PairChars];
    pair_info_t r;
    tbl = '{21'h0028, 21'h0029, 21'h003c, 21'h003e, 21'h005b, 21'h005d,
            21'h007b, 21'h007d, 21'h00ab, 21'h00bb, 21'h2018, 21'h2019,
            21'h201c, 21'h201d, 21'h2039, 21'h203a, 21'h3008, 21'h3009,
            21'h300a, 21'h300b, 21'h300c, 21'h300d, 21'h300e, 21'h300f,
            21'h3010, 21'h3011, 21'h3014, 21'h3015, 21'h3016, 21'h3017,
            21'h3018, 21'h3019, 21'h301a, 21'h301b};
    r = '0;
    for (int i = 0; i < PairChars; i++) begin
      if (tbl[i] == cp) begin
        r.hit = 1'b1;
        r.closer = i[0];
        r.pair = i[5:1];
      end
    end
    return r;
  endfunction

endpackage

FILE: src/script_run_segmenter.sv
// a character is taken in S_IDLE and tried in S_TRY, tried again in S_RETRY when it
// breaks the run, and its result is registered in S_OUT; a new character is not
// taken before the last result is through, since new input waits for the result transfer
// the closer search and the script fill-in cover all cells in one step
// reset: rst clears the run state, the state, the codes and m_tvalid; stack cells and data registers are not cleared
module script_run_segmenter #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // code_point, char_script
  input  logic        s_tlast,   // last_in_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // starts_run, ended_run_script,
                                 // current_run_script, stack_overflow
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  typedef enum logic [1:0] {S_IDLE, S_TRY, S_RETRY, S_OUT} st_t;
  st_t st, st_next;

  logic [7:0] common_code, inher_code;
  logic [20:0] cp;
  logic [7:0] sc_in;
  logic last;
  logic [7:0] run_script, ended;
  logic [CW-1:0] top, fne;
  logic at_start, starts, ovf;

  srs_pkg::pair_info_t pi;
  assign pi = srs_pkg::pair_lookup(cp);

  srs_pkg::stk_entry_t entries [STACK_DEPTH];
  logic [STACK_DEPTH-1:0] hits;
  logic [STACK_DEPTH:0] mchain;
  logic [STACK_DEPTH-1:0] wr_en, fill_en;

  // one try of the character
  logic is_open, is_close, brk, adopt, act;
  logic [CW-1:0] top1, fne1, top2, fne2;
  logic [7:0] sc1, rs2;
  srs_pkg::stk_entry_t push_entry;

  // stack cells only change while a try is running
  assign act = (st == S_TRY) || (st == S_RETRY);

  // working copies for this step (text start and retry applied)
  logic [7:0] rs0;
  logic [CW-1:0] fne0;
  always_comb begin
    rs0 = run_script;
    fne0 = fne;
    if (st == S_TRY && at_start) begin
      rs0 = srs_pkg::Undet;
      fne0 = top;
    end
    if (st == S_RETRY) begin
      rs0 = srs_pkg::Undet;
      fne0 = top;
    end
  end

  // new top after popping to the matching opener: highest hitting index + 1
  logic [CW-1:0] pop_top;
  always_comb begin
    pop_top = '0;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      if (hits[i]) pop_top = CW'(i + 1);
    end
  end

  genvar g;
  assign mchain[STACK_DEPTH] = 1'b0;
  generate
    for (g = 0; g < STACK_DEPTH; g++) begin : g_cell
      srs_cell u_cell (
        .clk(clk), .wr_en(wr_en[g]),
        .wr_data(push_entry),
        .fill_en(fill_en[g]), .fill_script(rs2),
        .want(pi.pair), .below_top(CW'(g) < top),
        .match_in(mchain[g+1]), .match_out(mchain[g]),
        .hit(hits[g]), .entry(entries[g])
      );
    end
  endgenerate

  function automatic logic joins(input logic [7:0] s, input logic [7:0] c,
                                 input logic [7:0] h);
    return s == srs_pkg::Undet || s == c || s == h;
  endfunction

  always_comb begin
    is_open = pi.hit && !pi.closer;
    is_close = pi.hit && pi.closer && top != '0;
    top1 = top;
    fne1 = fne0;
    sc1 = sc_in;
    wr_en = '0;
    if (is_open && top < CW'(STACK_DEPTH)) begin
      wr_en[top[IW-1:0]] = act;
      top1 = top + 1'b1;
    end
    if (is_close) begin
      top1 = mchain[0] ? pop_top : '0;
      if (top1 < fne1) fne1 = top1;
      if (top1 != '0) sc1 = entries[IW'(top1 - 1'b1)].script;
    end
    brk = !(joins(rs0, common_code, inher_code) || joins(sc1, common_code, inher_code)
            || rs0 == sc1);
    adopt = joins(rs0, common_code, inher_code) && !joins(sc1, common_code, inher_code);
    rs2 = adopt ? sc1 : rs0;
    top2 = top1;
    fne2 = fne1;
    fill_en = '0;
    if (adopt) begin
      for (int i = 0; i < STACK_DEPTH; i++) begin
        if (act && CW'(i) >= fne1 && CW'(i) < top1 && !wr_en[i]) fill_en[i] = 1'b1;
      end
      if (fne1 < top1) fne2 = top1;
    end
    if (is_close && top1 != '0) begin
      top2 = top1 - 1'b1;
      if (fne2 > top2) fne2 = top2;
    end
  end

  // a pushed opener already carries the script adopted in the same try
  assign push_entry = '{pair: pi.pair, script: rs2};

  assign s_tready = (st == S_IDLE) && !m_tvalid;

  always_comb begin
    st_next = st;
    case (st)
      S_IDLE:  if (s_tvalid && s_tready) st_next = S_TRY;
      S_TRY:   st_next = brk ? S_RETRY : S_OUT;
      S_RETRY: st_next = S_OUT;
      S_OUT:   st_next = S_IDLE;
      default: st_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      common_code <= 8'd0;
      inher_code <= 8'd40;
      run_script <= srs_pkg::Undet;
      top <= '0;
      fne <= '0;
      at_start <= 1'b1;
      m_tvalid <= 1'b0;
    end else begin
      st <= st_next;
      if (cfg_we) begin
        if (cfg_index) inher_code <= cfg_data;
        else common_code <= cfg_data;
      end
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (st)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            cp <= s_tdata[20:0];
            sc_in <= s_tdata[28:21];
            last <= s_tlast;
            starts <= at_start;
            ended <= srs_pkg::Undet;
            ovf <= 1'b0;
          end
        end
        S_TRY, S_RETRY: begin
          if (is_open && top >= CW'(STACK_DEPTH)) ovf <= 1'b1;
          at_start <= 1'b0;
          if (st == S_TRY && brk) begin
            // the failed try keeps its push or pop
            starts <= 1'b1;
            ended <= rs0;
            top <= top1;
            fne <= fne1;
          end else begin
            run_script <= rs2;
            top <= top2;
            fne <= fne2;
          end
        end
        S_OUT: begin
          m_tvalid <= 1'b1;
          m_tdata <= {6'd0, ovf, run_script, ended, starts};
          if (last) begin
            run_script <= srs_pkg::Undet;
            top <= '0;
            fne <= '0;
            at_start <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

FILE: src/srs_cell.sv
// one stack entry; the chain holds the stack with the top of stack at a count,
// every cell compares its pair against the searched pair and passes a match
// flag toward the bottom so each cell knows whether a match exists above it
module srs_cell (
  input  logic                  clk,
  input  logic                  wr_en,
  input  srs_pkg::stk_entry_t   wr_data,
  input  logic                  fill_en,
  input  logic [7:0]            fill_script,
  input  logic [4:0]            want,
  input  logic                  below_top,
  input  logic                  match_in,
  output logic                  match_out,
  output logic                  hit,
  output srs_pkg::stk_entry_t   entry
);
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry <= wr_data;
    end else if (fill_en) begin
      entry.script <= fill_script;
    end
  end

  assign hit = below_top && (entry.pair == want);
  assign match_out = match_in | hit;
endmodule
